### src/atr_pkg.sv
// Shared types and constants for the automaton table reachability core.
`timescale 1ns / 1ps

package atr_pkg;

  localparam int DEF_MAX_STATES  = 16;
  localparam int DEF_MAX_LETTERS = 4;

  // Register reset values and port widths
  localparam logic [4:0] STATES_RESET  = 5'd16;
  localparam logic [2:0] LETTERS_RESET = 3'd4;
  localparam int CFG_DATA_W = 5;

  // Register indexes
  localparam logic CFG_STATES  = 1'b0;
  localparam logic CFG_LETTERS = 1'b1;

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_INITIAL = 3'd2,
    CMD_FINAL   = 3'd3,
    CMD_QUERY   = 3'd4
  } opcode_t;

  // One command word, unpacked
  typedef struct packed {
    logic [3:0] to_state;
    logic [1:0] letter;
    logic [3:0] from_state;
    opcode_t    cmd;
  } cmd_t;

  // One result word, bit 0 = is_complete
  typedef struct packed {
    logic out_of_range;
    logic language_nonempty;
    logic is_complete;
  } res_t;

endpackage

### src/atr_table.sv
// Transition row store: one row of target bits per (state, letter), registered read.
`timescale 1ns / 1ps

module atr_table
  import atr_pkg::*;
#(
  parameter int MAX_STATES  = DEF_MAX_STATES,
  parameter int MAX_LETTERS = DEF_MAX_LETTERS,
  localparam int ROWS = MAX_STATES * MAX_LETTERS,
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [AW-1:0]         rd_addr,
  output logic [MAX_STATES-1:0] rd_data,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [MAX_STATES-1:0] wr_data
);

  logic [MAX_STATES-1:0] mem [ROWS];
  logic [ROWS-1:0]       row_valid;
  logic [MAX_STATES-1:0] rd_q;
  logic                  rd_valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // rows never written read as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      rd_valid_q <= row_valid[rd_addr];
    end
  end

  assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

### src/atr_seq.sv
// Command sequencer: table read-modify-write and the row sweep for queries.
`timescale 1ns / 1ps

module atr_seq
  import atr_pkg::*;
#(
  parameter int MAX_STATES  = DEF_MAX_STATES,
  parameter int MAX_LETTERS = DEF_MAX_LETTERS,
  localparam int ROWS = MAX_STATES * MAX_LETTERS,
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int SW   = $clog2(MAX_STATES),
  localparam int LW   = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1,
  localparam int CW   = $clog2(MAX_STATES + 1),
  localparam int LCW  = $clog2(MAX_LETTERS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CW-1:0]         ns,
  input  logic [LCW-1:0]        nl,
  input  logic [MAX_STATES-1:0] smask,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cmd_t                  cmd,
  input  logic                  res_ready,
  output logic                  done,
  output res_t                  res,
  output logic [AW-1:0]         rd_addr,
  input  logic [MAX_STATES-1:0] rd_data,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output logic [MAX_STATES-1:0] wr_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WAIT  = 5'b00010,
    S_RMW   = 5'b00100,
    S_SWEEP = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                state;
  cmd_t                  cmd_q;
  logic [AW-1:0]         rmw_addr;
  logic [AW-1:0]         cmd_addr;
  logic                  tr_oor;
  logic                  mk_oor;
  logic [MAX_STATES-1:0] initial_marks;
  logic [MAX_STATES-1:0] final_marks;
  logic [MAX_STATES-1:0] reached;
  logic [MAX_STATES-1:0] row;
  logic [MAX_STATES-1:0] to_bit;
  logic [SW-1:0]         s_cnt;
  logic [SW-1:0]         s_q;
  logic [LW-1:0]         l_cnt;
  logic [AW-1:0]         base;
  logic                  issue_done;
  logic                  dv;
  logic                  first;
  logic                  changed;
  logic                  complete;
  logic                  last_issue;
  logic                  last_letter;
  logic [SW-1:0]         from_s;

  assign from_s   = SW'(cmd.from_state);
  assign mk_oor   = 32'(cmd.from_state) >= 32'(ns);
  assign tr_oor   = mk_oor || (32'(cmd.letter) >= 32'(nl)) || (32'(cmd.to_state) >= 32'(ns));
  assign cmd_addr = AW'(AW'(from_s) * AW'(MAX_LETTERS)) + AW'(cmd.letter);

  assign last_letter = (LCW'(l_cnt) == nl - LCW'(1));
  assign last_issue  = last_letter && (CW'(s_cnt) == ns - CW'(1));
  assign row         = rd_data & smask;
  assign to_bit      = {{(MAX_STATES-1){1'b0}}, 1'b1} << cmd_q.to_state;

  assign in_ready = (state == S_IDLE);
  assign done     = (state == S_DONE);
  // the row being modified stays addressed until it is written back
  assign rd_addr  = (state == S_IDLE)  ? cmd_addr :
                    (state == S_SWEEP) ? base + AW'(l_cnt) : rmw_addr;
  assign wr_en    = (state == S_RMW);
  assign wr_addr  = rmw_addr;
  assign wr_data  = (cmd_q.cmd == CMD_ADD) ? (rd_data | to_bit) : (rd_data & ~to_bit);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      initial_marks <= '0;
      final_marks   <= '0;
      dv            <= 1'b0;
      issue_done    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q    <= cmd;
            rmw_addr <= cmd_addr;
            unique case (cmd.cmd)
              CMD_ADD, CMD_REMOVE: begin
                if (tr_oor) begin
                  res   <= '{out_of_range: 1'b1, default: 1'b0};
                  state <= S_DONE;
                end else begin
                  res   <= '0;
                  state <= S_WAIT;
                end
              end
              CMD_INITIAL, CMD_FINAL: begin
                res <= '{out_of_range: mk_oor, default: 1'b0};
                if (mk_oor) begin
                  // refused, marks untouched
                end else if (cmd.cmd == CMD_INITIAL) begin
                  initial_marks[from_s] <= 1'b1;
                end else begin
                  final_marks[from_s] <= 1'b1;
                end
                state <= S_DONE;
              end
              CMD_QUERY: begin
                res        <= '0;
                reached    <= initial_marks & smask;
                complete   <= 1'b1;
                first      <= 1'b1;
                changed    <= 1'b0;
                s_cnt      <= '0;
                l_cnt      <= '0;
                base       <= '0;
                issue_done <= 1'b0;
                dv         <= 1'b0;
                state      <= S_SWEEP;
              end
              default: begin
                res   <= '0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_WAIT: state <= S_RMW;
        S_RMW:  state <= S_DONE;
        S_SWEEP: begin
          // issue side
          if (!issue_done) begin
            if (last_issue) begin
              issue_done <= 1'b1;
            end else if (last_letter) begin
              l_cnt <= '0;
              s_cnt <= s_cnt + SW'(1);
              base  <= base + AW'(MAX_LETTERS);
            end else begin
              l_cnt <= l_cnt + LW'(1);
            end
          end
          dv  <= !issue_done;
          s_q <= s_cnt;
          // row returned from the store
          if (dv) begin
            if (reached[s_q]) begin
              reached <= reached | row;
              if ((row & ~reached) != '0) begin
                changed <= 1'b1;
              end
            end
            if (first && row == '0) begin
              complete <= 1'b0;
            end
          end
          // end of a round, pipe drained
          if (issue_done && !dv) begin
            if (changed) begin
              changed    <= 1'b0;
              first      <= 1'b0;
              s_cnt      <= '0;
              l_cnt      <= '0;
              base       <= '0;
              issue_done <= 1'b0;
            end else begin
              res   <= '{out_of_range:      1'b0,
                         language_nonempty: (reached & final_marks & smask) != '0,
                         is_complete:       complete};
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_write_only_in_rmw: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state == S_RMW)
    else $error("table written outside read-modify-write");

  a_oor_clean: assert property (@(posedge clk) disable iff (rst)
    done && res.out_of_range |-> !res.is_complete && !res.language_nonempty)
    else $error("out-of-range result carries query flags");

  a_reached_grows: assert property (@(posedge clk) disable iff (rst)
    state == S_SWEEP && $past(state) == S_SWEEP |-> (reached & $past(reached)) == $past(reached))
    else $error("reached set lost a state during sweep");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != S_IDLE)
    else $error("accepted word did not start a command");

endmodule

### src/automaton_table_reachability_core.sv
// Top level: stream ports, count registers and output stage of the reachability core.
`timescale 1ns / 1ps

// Keeps a finite automaton as a bit table (one row of target states per state and
// letter) plus initial and final marks, all empty after reset. Each input word is a
// command: add or remove one transition, mark a state initial or final, or query.
// Every command yields exactly one output word. A query reports is_complete (every
// state in use has a target in use for every letter in use) and language_nonempty
// (a final state in use is reachable from an initial state in use). Write commands
// with an index not below the count in use are dropped and flag out_of_range.
// Flow: s_tready is high only while the sequencer is idle. It drops after a mark, an
// unknown code or a refused write; a transition write drops it for the row read,
// the modify and the write back. A query sweeps the rows in use through the single
// registered read port of the table, one row per cycle, lets the read pipe drain at
// the end of each round, and repeats the round until the reached set stops growing;
// s_tready stays low for the whole query. s_tready also stays low while a finished
// word waits for the output register. The next command is taken while a finished
// word still waits on the master side.
// Count registers are taken as 0 -> 1 and above the maximum -> the maximum.

module automaton_table_reachability_core
  import atr_pkg::*;
#(
  parameter int MAX_STATES  = DEF_MAX_STATES,
  parameter int MAX_LETTERS = DEF_MAX_LETTERS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // cmd[2:0], from_state[6:3], letter[8:7], to_state[12:9]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata    // is_complete[0], language_nonempty[1], out_of_range[2]
);

  localparam int ROWS = MAX_STATES * MAX_LETTERS;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW   = $clog2(MAX_STATES + 1);
  localparam int LCW  = $clog2(MAX_LETTERS + 1);

  logic [4:0]            states_in_use;
  logic [2:0]            letters_in_use;
  logic [CW-1:0]         ns;
  logic [LCW-1:0]        nl;
  logic [MAX_STATES-1:0] smask;
  cmd_t                  cmd;
  res_t                  res;
  res_t                  m_res;
  logic                  done;
  logic                  res_ready;
  logic [AW-1:0]         rd_addr;
  logic [MAX_STATES-1:0] rd_data;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [MAX_STATES-1:0] wr_data;

  // count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      states_in_use  <= STATES_RESET;
      letters_in_use <= LETTERS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STATES:  states_in_use  <= cfg_data;
        CFG_LETTERS: letters_in_use <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // effective counts, clamped to 1..max
  always_comb begin
    if (states_in_use == '0) begin
      ns = CW'(1);
    end else if (32'(states_in_use) > MAX_STATES) begin
      ns = CW'(MAX_STATES);
    end else begin
      ns = CW'(states_in_use);
    end
    if (letters_in_use == '0) begin
      nl = LCW'(1);
    end else if (32'(letters_in_use) > MAX_LETTERS) begin
      nl = LCW'(MAX_LETTERS);
    end else begin
      nl = LCW'(letters_in_use);
    end
  end

  // states in use
  always_comb begin
    for (int i = 0; i < MAX_STATES; i++) begin
      smask[i] = (32'(i) < 32'(ns));
    end
  end

  assign cmd = cmd_t'(s_tdata[12:0]);

  // output register: free when empty or being drained this cycle
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && res_ready) begin
      m_res <= res;
    end
  end

  assign m_tdata = {5'b0, m_res};

  atr_seq #(
    .MAX_STATES  (MAX_STATES),
    .MAX_LETTERS (MAX_LETTERS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .ns        (ns),
    .nl        (nl),
    .smask     (smask),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .cmd       (cmd),
    .res_ready (res_ready),
    .done      (done),
    .res       (res),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  atr_table #(
    .MAX_STATES  (MAX_STATES),
    .MAX_LETTERS (MAX_LETTERS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

### bench/automaton_table_reachability_core_tb.sv
// Self-checking bench for the automaton table reachability core: directed table, then random phases.
`timescale 1ns / 1ps

module automaton_table_reachability_core_tb
  import atr_pkg::*;
();

  localparam int STATE_SLOTS     = DEF_MAX_STATES;
  localparam int LETTER_SLOTS    = DEF_MAX_LETTERS;
  localparam int RANDOM_PHASES   = 18;
  localparam int WORDS_PER_PHASE = 96;
  localparam int IDLE_PERCENT    = 29;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STUCK_LIMIT     = 6000;   // room for the longest query, plus stalls
  localparam int TAIL_CYCLES     = 20;

  // cmd codes the block does not know
  localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
  localparam logic [2:0] CMD_UNUSED_MID = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;

  // Verdicts that can be read straight off a command
  localparam res_t RES_NONE      = 3'b000;
  localparam res_t RES_OOR       = 3'b100;
  localparam res_t RES_REACHABLE = 3'b010;

  typedef enum logic {ROW_WORD, ROW_COUNTS} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [2:0]            op;
    logic [3:0]            src;
    logic [1:0]            ltr;
    logic [3:0]            dst;
    logic [CFG_DATA_W-1:0] n_states;
    logic [CFG_DATA_W-1:0] n_letters;
    bit                    typed;   // verdict typed in rather than predicted
    res_t                  want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [15:0]           s_tdata;   // cmd[2:0], from_state[6:3], letter[8:7], to_state[12:9]
  logic                  m_tvalid;
  logic                  m_tready;
  logic [7:0]            m_tdata;   // is_complete[0], language_nonempty[1], out_of_range[2]

  // Shadow copy of the automaton and the count registers
  logic [15:0] row_targets [STATE_SLOTS*LETTER_SLOTS];
  logic [15:0] initial_set;
  logic [15:0] final_set;
  logic [4:0]  states_reg;
  logic [2:0]  letters_reg;

  res_t pending_verdicts [$];

  bit steady        = 1'b0;   // no idling on either side
  bit hold_off_req  = 1'b0;
  bit hold_off_done = 1'b0;
  int mismatches    = 0;
  int words_sent    = 0;
  int queries_sent  = 0;
  int settings_used = 0;
  int verdicts_seen = 0;
  int complete_hits = 0;
  int nonempty_hits = 0;
  int oor_hits      = 0;
  int stuck_cycles  = 0;

  automaton_table_reachability_core uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Counts of zero act as one, counts past the table size act as the size
  function automatic int clamp_count(int v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Applies one command word to the shadow automaton and returns its verdict
  function automatic res_t apply_command(logic [2:0] op, logic [3:0] src, logic [1:0] ltr,
                                         logic [3:0] dst);
    int ns, nl, s, l, idx;
    logic [15:0] mask, reached, grown;
    res_t r;
    ns = clamp_count(int'(states_reg), STATE_SLOTS);
    nl = clamp_count(int'(letters_reg), LETTER_SLOTS);
    mask = (ns >= STATE_SLOTS) ? 16'hFFFF : 16'((1 << ns) - 1);
    r = RES_NONE;
    case (op)
      CMD_ADD, CMD_REMOVE: begin
        if (int'(src) >= ns || int'(ltr) >= nl || int'(dst) >= ns) begin
          r.out_of_range = 1'b1;
        end else begin
          idx = int'(src) * LETTER_SLOTS + int'(ltr);
          row_targets[idx][dst] = (op == CMD_ADD);
        end
      end
      CMD_INITIAL, CMD_FINAL: begin
        if (int'(src) >= ns) r.out_of_range = 1'b1;
        else if (op == CMD_INITIAL) initial_set[src] = 1'b1;
        else final_set[src] = 1'b1;
      end
      CMD_QUERY: begin
        r.is_complete = 1'b1;
        for (s = 0; s < ns; s++)
          for (l = 0; l < nl; l++)
            if ((row_targets[s*LETTER_SLOTS+l] & mask) == 16'h0000) r.is_complete = 1'b0;
        // grow the reached set until it stops changing
        grown = initial_set & mask;
        do begin
          reached = grown;
          for (s = 0; s < ns; s++)
            if (reached[s])
              for (l = 0; l < nl; l++) grown |= row_targets[s*LETTER_SLOTS+l] & mask;
        end while (grown != reached);
        r.language_nonempty = |(reached & final_set & mask);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic plan_row_t word_row(logic [2:0] op, logic [3:0] src, logic [1:0] ltr,
                                         logic [3:0] dst, bit typed, res_t want);
    return '{ROW_WORD, op, src, ltr, dst, 5'd0, 5'd0, typed, want};
  endfunction

  function automatic plan_row_t counts_row(logic [CFG_DATA_W-1:0] n_states,
                                           logic [CFG_DATA_W-1:0] n_letters);
    return '{ROW_COUNTS, 3'd0, 4'd0, 2'd0, 4'd0, n_states, n_letters, 1'b0, RES_NONE};
  endfunction

  // Offers one command word, possibly after a random gap, and books its verdict on acceptance
  task automatic send_word(input logic [2:0] op, input logic [3:0] src, input logic [1:0] ltr,
                           input logic [3:0] dst, input bit typed, input res_t want);
    res_t predicted;
    int gap;
    if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      gap = ($urandom_range(9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, dst, ltr, src, op};
    do @(posedge clk); while (!s_tready);
    predicted = apply_command(op, src, ltr, dst);
    pending_verdicts.push_back(typed ? want : predicted);
    words_sent++;
    if (op == CMD_QUERY) queries_sent++;
  endtask

  // Stops offering and waits for every booked verdict to come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // Writes both count registers; block must be idle
  task automatic set_counts(input logic [CFG_DATA_W-1:0] n_states,
                            input logic [CFG_DATA_W-1:0] n_letters);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STATES;
    cfg_data  <= n_states;
    @(posedge clk);
    states_reg = n_states;
    cfg_index <= CFG_LETTERS;
    cfg_data  <= n_letters;
    @(posedge clk);
    letters_reg = n_letters[2:0];
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Result side: random back-pressure, one long hold-off on request
  initial begin : receiver
    m_tready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end
      m_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Each accepted result word against the oldest booked verdict
  always @(posedge clk) begin : verdict_check
    res_t got;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = res_t'(m_tdata[2:0]);
      if (pending_verdicts.size() == 0) begin
        $error("result word %b with no command pending", m_tdata);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (got.is_complete !== want.is_complete) begin
          $error("is_complete: expected %0b, got %0b", want.is_complete, got.is_complete);
          mismatches++;
        end
        if (got.language_nonempty !== want.language_nonempty) begin
          $error("language_nonempty: expected %0b, got %0b",
                 want.language_nonempty, got.language_nonempty);
          mismatches++;
        end
        if (got.out_of_range !== want.out_of_range) begin
          $error("out_of_range: expected %0b, got %0b", want.out_of_range, got.out_of_range);
          mismatches++;
        end
        verdicts_seen++;
        if (want.is_complete) complete_hits++;
        if (want.language_nonempty) nonempty_hits++;
        if (want.out_of_range) oor_hits++;
      end
    end
  end

  // Ends the run when neither side moves a word for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("[automaton_table_reachability_core] ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stimulus
    plan_row_t plan [$];
    int ns, nl, sent, pick, hops, k, s, l;
    bit drained_mid;
    logic [3:0] a, b;
    logic [1:0] c;
    logic [2:0] op;
    logic [CFG_DATA_W-1:0] sv, lv;

    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = CFG_STATES;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    foreach (row_targets[i]) row_targets[i] = 16'h0000;
    initial_set = 16'h0000;
    final_set   = 16'h0000;
    states_reg  = STATES_RESET;
    letters_reg = LETTERS_RESET;
    drained_mid = 1'b0;

    // Full 16 x 4 after reset
    plan.push_back(word_row(CMD_QUERY,      4'd0,  2'd0, 4'd0,  1'b1, RES_NONE));  // empty
    plan.push_back(word_row(CMD_UNUSED_HI,  4'd15, 2'd3, 4'd15, 1'b1, RES_NONE));
    plan.push_back(word_row(CMD_ADD,        4'd15, 2'd3, 4'd15, 1'b1, RES_NONE));
    plan.push_back(word_row(CMD_REMOVE,     4'd0,  2'd0, 4'd0,  1'b1, RES_NONE));  // absent
    plan.push_back(word_row(CMD_ADD,        4'd0,  2'd0, 4'd15, 1'b1, RES_NONE));
    plan.push_back(word_row(CMD_ADD,        4'd0,  2'd0, 4'd15, 1'b1, RES_NONE));  // present
    plan.push_back(word_row(CMD_INITIAL,    4'd0,  2'd0, 4'd0,  1'b1, RES_NONE));
    plan.push_back(word_row(CMD_FINAL,      4'd15, 2'd0, 4'd0,  1'b1, RES_NONE));
    plan.push_back(word_row(CMD_QUERY,      4'd15, 2'd3, 4'd15, 1'b1, RES_REACHABLE));
    // Shrunk to 3 states, 2 letters: each index at or above the count is refused
    plan.push_back(counts_row(5'd3, 5'd2));
    plan.push_back(word_row(CMD_ADD,        4'd3,  2'd0, 4'd0,  1'b1, RES_OOR));
    plan.push_back(word_row(CMD_ADD,        4'd0,  2'd2, 4'd0,  1'b1, RES_OOR));
    plan.push_back(word_row(CMD_REMOVE,     4'd0,  2'd0, 4'd3,  1'b1, RES_OOR));
    plan.push_back(word_row(CMD_INITIAL,    4'd3,  2'd0, 4'd0,  1'b1, RES_OOR));
    plan.push_back(word_row(CMD_FINAL,      4'd15, 2'd0, 4'd0,  1'b1, RES_OOR));
    plan.push_back(word_row(CMD_QUERY,      4'd0,  2'd0, 4'd0,  1'b0, RES_NONE));  // final 15 hidden
    plan.push_back(word_row(CMD_FINAL,      4'd0,  2'd0, 4'd0,  1'b1, RES_NONE));
    plan.push_back(word_row(CMD_QUERY,      4'd0,  2'd0, 4'd0,  1'b0, RES_NONE));  // initial+final
    // Zero counts act as one state, one letter
    plan.push_back(counts_row(5'd0, 5'd0));
    plan.push_back(word_row(CMD_ADD,        4'd0,  2'd0, 4'd0,  1'b1, RES_NONE));
    plan.push_back(word_row(CMD_ADD,        4'd1,  2'd0, 4'd0,  1'b1, RES_OOR));
    plan.push_back(word_row(CMD_QUERY,      4'd0,  2'd0, 4'd0,  1'b0, RES_NONE));
    plan.push_back(word_row(CMD_UNUSED_LO,  4'd0,  2'd0, 4'd0,  1'b1, RES_NONE));
    // Counts past the maximum act as the maximum
    plan.push_back(counts_row(5'd31, 5'd7));
    plan.push_back(word_row(CMD_QUERY,      4'd0,  2'd0, 4'd0,  1'b0, RES_NONE));
    plan.push_back(word_row(CMD_REMOVE,     4'd15, 2'd3, 4'd15, 1'b0, RES_NONE));
    plan.push_back(word_row(CMD_UNUSED_MID, 4'd9,  2'd1, 4'd6,  1'b1, RES_NONE));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_COUNTS) begin
        drain();
        set_counts(plan[i].n_states, plan[i].n_letters);
      end else begin
        send_word(plan[i].op, plan[i].src, plan[i].ltr, plan[i].dst, plan[i].typed,
                  plan[i].want);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      // mostly small automata so queries stay quick; now and then the extremes
      pick = $urandom_range(9);
      case (pick)
        0:       sv = 5'd0;
        1:       sv = 5'($urandom_range(17, 31));
        2:       sv = 5'd16;
        3:       sv = 5'($urandom_range(7, 15));
        default: sv = 5'($urandom_range(1, 6));
      endcase
      if (ph == RANDOM_PHASES - 1) sv = 5'd16;
      pick = $urandom_range(7);
      lv = (pick == 0) ? 5'd0 : (pick == 1) ? 5'($urandom_range(5, 31)) :
           5'($urandom_range(1, 4));
      set_counts(sv, lv);
      ns = clamp_count(int'(states_reg), STATE_SLOTS);
      nl = clamp_count(int'(letters_reg), LETTER_SLOTS);
      steady = (ph == 3);
      sent = 0;

      while (sent < WORDS_PER_PHASE) begin
        if (ph == 5 && sent >= 10) hold_off_req = 1'b1;
        if (ph == 7 && sent >= 40 && !drained_mid) begin
          drain();
          drained_mid = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 6) begin
          // noise: any code, any indices
          send_word(3'($urandom_range(7)), 4'($urandom_range(15)), 2'($urandom_range(3)),
                    4'($urandom_range(15)), 1'b0, RES_NONE);
          sent++;
        end else if (pick < 16) begin
          // a path from an initial state to a final state, then a query
          hops = $urandom_range(1, 3);
          a = 4'($urandom_range(ns - 1));
          send_word(CMD_INITIAL, a, 2'($urandom_range(3)), 4'($urandom_range(15)),
                    1'b0, RES_NONE);
          for (k = 0; k < hops; k++) begin
            b = 4'($urandom_range(ns - 1));
            c = 2'($urandom_range(nl - 1));
            send_word(CMD_ADD, a, c, b, 1'b0, RES_NONE);
            a = b;
          end
          send_word(CMD_FINAL, a, 2'($urandom_range(3)), 4'($urandom_range(15)),
                    1'b0, RES_NONE);
          send_word(CMD_QUERY, 4'($urandom_range(15)), 2'($urandom_range(3)),
                    4'($urandom_range(15)), 1'b0, RES_NONE);
          sent += hops + 3;
        end else if (pick < 20 && ns * nl <= 24) begin
          // give every row in use a target, then ask whether it is complete
          for (s = 0; s < ns; s++)
            for (l = 0; l < nl; l++)
              send_word(CMD_ADD, 4'(s), 2'(l), 4'($urandom_range(ns - 1)), 1'b0, RES_NONE);
          send_word(CMD_QUERY, 4'($urandom_range(15)), 2'($urandom_range(3)),
                    4'($urandom_range(15)), 1'b0, RES_NONE);
          sent += ns * nl + 1;
        end else begin
          pick = $urandom_range(99);
          if (pick < 33)      op = CMD_ADD;
          else if (pick < 62) op = CMD_REMOVE;
          else if (pick < 69) op = CMD_INITIAL;
          else if (pick < 76) op = CMD_FINAL;
          else if (pick < 94) op = CMD_QUERY;
          else                op = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
          if ($urandom_range(9) == 0) begin
            send_word(op, 4'($urandom_range(15)), 2'($urandom_range(3)),
                      4'($urandom_range(15)), 1'b0, RES_NONE);
          end else begin
            send_word(op, 4'($urandom_range(ns - 1)), 2'($urandom_range(nl - 1)),
                      4'($urandom_range(ns - 1)), 1'b0, RES_NONE);
          end
          sent++;
        end
      end
    end
    steady = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d command words (%0d queries) over %0d count settings.",
             words_sent, queries_sent, settings_used);
    $display("%0d verdicts checked: %0d complete, %0d reachable, %0d refused as out of range.",
             verdicts_seen, complete_hits, nonempty_hits, oor_hits);
    if (mismatches == 0) begin
      $display("[automaton_table_reachability_core] OK");
    end else begin
      $display("[automaton_table_reachability_core] ERROR");
    end
    $finish;
  end

endmodule
